// ===== design/ceam_pkg.sv =====
// Shared types, constants and helpers of the cluster extent allocator and mapper.
// Used by the RAM-backed datapath, the controller and the top level.
`default_nettype none

package ceam_pkg;

    localparam int MAX_ENTRIES         = 12;
    // Sector and cluster sizes must be powers of two.
    localparam int SECTOR_BYTES        = 512;
    localparam int SECTORS_PER_CLUSTER = 8;

    localparam int CLUSTER_BYTES = SECTOR_BYTES * SECTORS_PER_CLUSTER;
    localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
    localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
    localparam int SPC_SHIFT     = $clog2(SECTORS_PER_CLUSTER);
    localparam int SPC_MASK      = SECTORS_PER_CLUSTER - 1;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SEL_W  = 4;
    localparam int CMP_W  = (CNT_W > SEL_W) ? CNT_W : SEL_W;
    localparam int LEN_W  = 10;
    localparam int BOFF_W = 9;
    localparam int LSUM_W = $clog2(SECTOR_BYTES) + 2;

    localparam logic [1:0] CFG_AREA_START = 2'd0;
    localparam logic [1:0] CFG_AREA_END   = 2'd1;
    localparam logic [1:0] CFG_HEAP_SECT  = 2'd2;
    localparam logic [1:0] CFG_HEAP_CLUS  = 2'd3;

    typedef logic [31:0]              word_t;
    typedef logic [32:0]              wide_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [SEL_W-1:0]         sel_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [BOFF_W-1:0]        boff_t;
    typedef logic [LSUM_W-1:0]        lsum_t;
    typedef logic [CLUSTER_SHIFT-1:0] incl_t;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_RESIZE = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NO_ENTRY  = 3'd2,
        ST_NO_GROW   = 3'd3,
        ST_BAD_ENTRY = 3'd4,
        ST_UNMAPPED  = 3'd5,
        ST_PAST_END  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_BAD_CMD,
        DP_A_NEED,
        DP_A_COMMIT,
        DP_R_BAD,
        DP_R_CALC,
        DP_R_CHK,
        DP_R_FIN,
        DP_L_PREP,
        DP_L_CLUS,
        DP_L_UNMAP,
        DP_L_CAPTURE,
        DP_L_OFFS,
        DP_L_FIN
    } dp_op_t;

    typedef struct packed {
        word_t first;
        word_t size;
        wide_t end_cluster;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        dp_op_t op;
        logic   scan;
        idx_t   scan_idx;
        idx_t   match_idx;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic sel_bad;
        cnt_t count;
        logic below;
        logic hit;
    } stat_t;

    typedef struct packed {
        status_t status;
        word_t   alloc_cluster;
        sel_t    matched_entry;
        word_t   file_pos;
        len_t    copy_length;
        len_t    fill_length;
    } result_t;

    function automatic wide_t clusters_for(word_t bytes);
        return wide_t'((wide_t'(bytes) + wide_t'(CLUSTER_BYTES - 1)) >> CLUSTER_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== design/ceam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ceam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/ceam_dpath.sv =====
// Datapath: configuration registers, bump pointer, extent table RAM and
// the arithmetic of allocate, resize and lookup. Uses ceam_pkg and ceam_ram.
`default_nettype none

module ceam_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic [1:0]           command,
    input  wire logic [31:0]          req_bytes,
    input  wire logic [3:0]           entry_select,
    input  wire logic [31:0]          sector_address,
    input  wire logic [8:0]           byte_offset,
    input  wire logic [9:0]           read_length,
    input  wire ceam_pkg::ctrl_t      ctrl,
    output ceam_pkg::stat_t           stat,
    output ceam_pkg::result_t         result
);

    ceam_pkg::word_t   area_end_reg;
    ceam_pkg::word_t   heap_sect_reg;
    ceam_pkg::word_t   heap_clus_reg;
    ceam_pkg::word_t   nfc_reg;
    ceam_pkg::cnt_t    count_reg;

    ceam_pkg::cmd_t    cmd_reg;
    ceam_pkg::word_t   size_reg;
    ceam_pkg::sel_t    sel_reg;
    ceam_pkg::word_t   lba_reg;
    ceam_pkg::boff_t   boff_reg;
    ceam_pkg::len_t    len_in_reg;

    ceam_pkg::wide_t   need_reg;
    ceam_pkg::wide_t   have_reg;
    ceam_pkg::wide_t   add_reg;
    ceam_pkg::wide_t   end_new_reg;
    ceam_pkg::word_t   first_reg;
    ceam_pkg::word_t   hsize_reg;
    logic              grow_reg;
    logic              more_reg;
    logic              last_reg;
    ceam_pkg::lsum_t   len_reg;
    logic              below_reg;
    ceam_pkg::word_t   rel_reg;
    ceam_pkg::wide_t   cluster_reg;
    ceam_pkg::incl_t   incl_reg;
    ceam_pkg::word_t   fo_reg;
    ceam_pkg::idx_t    match_reg;
    ceam_pkg::result_t result_reg;

    logic                          ram_we;
    ceam_pkg::idx_t                ram_waddr;
    ceam_pkg::entry_t              ram_wentry;
    ceam_pkg::idx_t                ram_raddr;
    logic [ceam_pkg::ENTRY_W-1:0]  ram_rdata;
    ceam_pkg::entry_t              rd_entry;

    ceam_pkg::wide_t   alloc_sum;
    logic              alloc_full;
    logic              table_full;
    ceam_pkg::wide_t   grow_sum;
    logic              grow_refused;
    ceam_pkg::lsum_t   len_sum;
    ceam_pkg::word_t   remain;
    ceam_pkg::lsum_t   take_len;
    ceam_pkg::wide_t   clus_diff;

    assign rd_entry  = ceam_pkg::entry_t'(ram_rdata);
    assign ram_raddr = ctrl.scan ? ctrl.scan_idx : ceam_pkg::idx_t'(sel_reg);

    assign alloc_sum  = ceam_pkg::wide_t'(nfc_reg) + need_reg;
    assign alloc_full = alloc_sum >= ceam_pkg::wide_t'(area_end_reg);
    assign table_full = count_reg >= ceam_pkg::cnt_t'(ceam_pkg::MAX_ENTRIES);

    assign grow_sum     = ceam_pkg::wide_t'(nfc_reg) + add_reg;
    assign grow_refused = grow_reg && more_reg &&
                          !(last_reg && (grow_sum <= ceam_pkg::wide_t'(area_end_reg)));

    assign len_sum   = ceam_pkg::lsum_t'(boff_reg) + ceam_pkg::lsum_t'(len_in_reg);
    assign remain    = hsize_reg - fo_reg;
    assign take_len  = (remain < ceam_pkg::word_t'(len_reg)) ? ceam_pkg::lsum_t'(remain)
                                                             : len_reg;
    assign clus_diff = cluster_reg - ceam_pkg::wide_t'(first_reg);

    assign stat.cmd     = cmd_reg;
    assign stat.sel_bad = ceam_pkg::cmp_t'(sel_reg) >= ceam_pkg::cmp_t'(count_reg);
    assign stat.count   = count_reg;
    assign stat.below   = below_reg;
    assign stat.hit     = (ceam_pkg::wide_t'(rd_entry.first) <= cluster_reg) &&
                          (cluster_reg < rd_entry.end_cluster);

    assign result = result_reg;

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = ceam_pkg::idx_t'(sel_reg);
        ram_wentry = '{first: first_reg, size: size_reg, end_cluster: end_new_reg};
        case (ctrl.op)
            ceam_pkg::DP_A_COMMIT:
            begin
                ram_we     = !alloc_full && !table_full;
                ram_waddr  = ceam_pkg::idx_t'(count_reg);
                ram_wentry = '{first: nfc_reg, size: size_reg, end_cluster: alloc_sum};
            end
            ceam_pkg::DP_R_FIN:
            begin
                ram_we = !grow_refused;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ceam_ram #(
        .WIDTH (ceam_pkg::ENTRY_W),
        .DEPTH (ceam_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_end_reg   <= 32'd0;
            heap_sect_reg  <= 32'd0;
            heap_clus_reg  <= 32'd2;
            nfc_reg        <= 32'd2;
            count_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ceam_pkg::CFG_AREA_START:
                begin
                    nfc_reg        <= cfg_data;
                end
                ceam_pkg::CFG_AREA_END:  area_end_reg  <= cfg_data;
                ceam_pkg::CFG_HEAP_SECT: heap_sect_reg <= cfg_data;
                ceam_pkg::CFG_HEAP_CLUS: heap_clus_reg <= cfg_data;
                default:                 area_end_reg  <= area_end_reg;
            endcase
        end
        else
        begin
            case (ctrl.op)
                ceam_pkg::DP_A_COMMIT:
                begin
                    if (!alloc_full && !table_full)
                    begin
                        nfc_reg   <= ceam_pkg::word_t'(alloc_sum);
                        count_reg <= count_reg + ceam_pkg::cnt_t'(1);
                    end
                end
                ceam_pkg::DP_R_FIN:
                begin
                    if (!grow_refused && grow_reg && more_reg)
                    begin
                        nfc_reg <= ceam_pkg::word_t'(grow_sum);
                    end
                end
                default:
                begin
                    nfc_reg <= nfc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            ceam_pkg::DP_LATCH:
            begin
                cmd_reg    <= ceam_pkg::cmd_t'(command);
                size_reg   <= req_bytes;
                sel_reg    <= entry_select;
                lba_reg    <= sector_address;
                boff_reg   <= byte_offset;
                len_in_reg <= read_length;
            end
            ceam_pkg::DP_BAD_CMD:
            begin
                result_reg <= '{ceam_pkg::ST_BAD_ENTRY, '0, '0, '0, '0, '0};
            end
            ceam_pkg::DP_A_NEED:
            begin
                need_reg <= ceam_pkg::clusters_for(size_reg);
            end
            ceam_pkg::DP_A_COMMIT:
            begin
                if (alloc_full)
                begin
                    result_reg <= '{ceam_pkg::ST_NO_SPACE, '0, '0, '0, '0, '0};
                end
                else if (table_full)
                begin
                    result_reg <= '{ceam_pkg::ST_NO_ENTRY, '0, '0, '0, '0, '0};
                end
                else
                begin
                    result_reg <= '{ceam_pkg::ST_OK, nfc_reg,
                                    ceam_pkg::sel_t'(count_reg), '0, '0, '0};
                end
            end
            ceam_pkg::DP_R_BAD:
            begin
                result_reg <= '{ceam_pkg::ST_BAD_ENTRY, '0, sel_reg, '0, '0, '0};
            end
            ceam_pkg::DP_R_CALC:
            begin
                first_reg <= rd_entry.first;
                grow_reg  <= size_reg > rd_entry.size;
                need_reg  <= ceam_pkg::clusters_for(size_reg);
                have_reg  <= ceam_pkg::clusters_for(rd_entry.size);
            end
            ceam_pkg::DP_R_CHK:
            begin
                add_reg     <= need_reg - have_reg;
                more_reg    <= need_reg > have_reg;
                last_reg    <= (ceam_pkg::wide_t'(first_reg) + have_reg) ==
                               ceam_pkg::wide_t'(nfc_reg);
                end_new_reg <= ceam_pkg::wide_t'(first_reg) + need_reg;
            end
            ceam_pkg::DP_R_FIN:
            begin
                if (grow_refused)
                begin
                    result_reg <= '{ceam_pkg::ST_NO_GROW, '0, sel_reg, '0, '0, '0};
                end
                else
                begin
                    result_reg <= '{ceam_pkg::ST_OK, '0, sel_reg, '0, '0, '0};
                end
            end
            ceam_pkg::DP_L_PREP:
            begin
                if (len_sum > ceam_pkg::lsum_t'(ceam_pkg::SECTOR_BYTES))
                begin
                    len_reg <= ceam_pkg::lsum_t'(ceam_pkg::SECTOR_BYTES) -
                               ceam_pkg::lsum_t'(boff_reg);
                end
                else
                begin
                    len_reg <= ceam_pkg::lsum_t'(len_in_reg);
                end
                below_reg <= lba_reg < heap_sect_reg;
                rel_reg   <= lba_reg - heap_sect_reg;
            end
            ceam_pkg::DP_L_CLUS:
            begin
                cluster_reg <= ceam_pkg::wide_t'(rel_reg >> ceam_pkg::SPC_SHIFT) +
                               ceam_pkg::wide_t'(heap_clus_reg);
                incl_reg    <= ceam_pkg::incl_t'((rel_reg & ceam_pkg::word_t'(ceam_pkg::SPC_MASK))
                                                 << ceam_pkg::SECTOR_SHIFT) |
                               ceam_pkg::incl_t'(boff_reg);
            end
            ceam_pkg::DP_L_UNMAP:
            begin
                result_reg <= '{ceam_pkg::ST_UNMAPPED, '0, '0, '0, '0,
                                ceam_pkg::len_t'(len_reg)};
            end
            ceam_pkg::DP_L_CAPTURE:
            begin
                first_reg <= rd_entry.first;
                hsize_reg <= rd_entry.size;
                match_reg <= ctrl.match_idx;
            end
            ceam_pkg::DP_L_OFFS:
            begin
                fo_reg <= ceam_pkg::word_t'(clus_diff << ceam_pkg::CLUSTER_SHIFT) |
                          ceam_pkg::word_t'(incl_reg);
            end
            ceam_pkg::DP_L_FIN:
            begin
                if (fo_reg >= hsize_reg)
                begin
                    result_reg <= '{ceam_pkg::ST_PAST_END, '0, ceam_pkg::sel_t'(match_reg),
                                    '0, '0, ceam_pkg::len_t'(len_reg)};
                end
                else
                begin
                    result_reg <= '{ceam_pkg::ST_OK, '0, ceam_pkg::sel_t'(match_reg), fo_reg,
                                    ceam_pkg::len_t'(take_len),
                                    ceam_pkg::len_t'(len_reg - take_len)};
                end
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ceam_ctrl.sv =====
// Controller: sequences each request through the datapath and walks the
// extent table on lookup. Uses ceam_pkg.
`default_nettype none

module ceam_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ceam_pkg::stat_t stat,
    output ceam_pkg::ctrl_t      ctrl,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_NEED,
        S_A_COMMIT,
        S_R_CALC,
        S_R_CHK,
        S_R_FIN,
        S_L_PREP,
        S_L_CLUS,
        S_L_SCAN,
        S_L_OFFS,
        S_L_FIN
    } state_t;

    state_t          state_reg;
    logic            busy_reg;
    logic            done_reg;
    ceam_pkg::cnt_t  scan_idx_reg;
    logic            pend_reg;
    ceam_pkg::idx_t  pend_idx_reg;
    logic            more_scan;

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign more_scan = scan_idx_reg < stat.count;

    always_comb
    begin
        ctrl.op        = ceam_pkg::DP_NONE;
        ctrl.scan      = state_reg == S_L_SCAN;
        ctrl.scan_idx  = ceam_pkg::idx_t'(scan_idx_reg);
        ctrl.match_idx = pend_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.op = ceam_pkg::DP_LATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    ceam_pkg::CMD_ALLOC:  ctrl.op = ceam_pkg::DP_NONE;
                    ceam_pkg::CMD_RESIZE: ctrl.op = stat.sel_bad ? ceam_pkg::DP_R_BAD
                                                                 : ceam_pkg::DP_NONE;
                    ceam_pkg::CMD_LOOKUP: ctrl.op = ceam_pkg::DP_NONE;
                    default:              ctrl.op = ceam_pkg::DP_BAD_CMD;
                endcase
            end
            S_A_NEED:   ctrl.op = ceam_pkg::DP_A_NEED;
            S_A_COMMIT: ctrl.op = ceam_pkg::DP_A_COMMIT;
            S_R_CALC:   ctrl.op = ceam_pkg::DP_R_CALC;
            S_R_CHK:    ctrl.op = ceam_pkg::DP_R_CHK;
            S_R_FIN:    ctrl.op = ceam_pkg::DP_R_FIN;
            S_L_PREP:   ctrl.op = ceam_pkg::DP_L_PREP;
            S_L_CLUS:   ctrl.op = stat.below ? ceam_pkg::DP_L_UNMAP : ceam_pkg::DP_L_CLUS;
            S_L_SCAN:
            begin
                if (pend_reg && stat.hit)
                begin
                    ctrl.op = ceam_pkg::DP_L_CAPTURE;
                end
                else if (!more_scan)
                begin
                    ctrl.op = ceam_pkg::DP_L_UNMAP;
                end
            end
            S_L_OFFS:   ctrl.op = ceam_pkg::DP_L_OFFS;
            S_L_FIN:    ctrl.op = ceam_pkg::DP_L_FIN;
            default:    ctrl.op = ceam_pkg::DP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg  <= 1'b1;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (stat.cmd)
                        ceam_pkg::CMD_ALLOC:
                        begin
                            state_reg <= S_A_NEED;
                        end
                        ceam_pkg::CMD_RESIZE:
                        begin
                            if (stat.sel_bad)
                            begin
                                done_reg  <= 1'b1;
                                busy_reg  <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_R_CALC;
                            end
                        end
                        ceam_pkg::CMD_LOOKUP:
                        begin
                            state_reg <= S_L_PREP;
                        end
                        default:
                        begin
                            done_reg  <= 1'b1;
                            busy_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_A_NEED:   state_reg <= S_A_COMMIT;
                S_R_CALC:   state_reg <= S_R_CHK;
                S_R_CHK:    state_reg <= S_R_FIN;
                S_L_PREP:   state_reg <= S_L_CLUS;
                S_L_CLUS:
                begin
                    if (stat.below)
                    begin
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        scan_idx_reg <= '0;
                        pend_reg     <= 1'b0;
                        state_reg    <= S_L_SCAN;
                    end
                end
                S_L_SCAN:
                begin
                    if (pend_reg && stat.hit)
                    begin
                        state_reg <= S_L_OFFS;
                    end
                    else if (more_scan)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= ceam_pkg::idx_t'(scan_idx_reg);
                        scan_idx_reg <= scan_idx_reg + ceam_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_L_OFFS:   state_reg <= S_L_FIN;
                S_A_COMMIT, S_R_FIN, S_L_FIN:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/cluster_extent_allocator_mapper_core.sv =====
// Top level of the cluster extent allocator and sector-read mapper.
// Depends on ceam_pkg, ceam_ctrl, ceam_dpath (and through it ceam_ram).
//
// A request is taken when start is high and busy is low; its one result appears
// with done high for a single cycle and cannot be held off, so capture it then.
// Allocate and resize each step through their own states; a resize of a bad entry
// and an unused command end right after dispatch. Lookup walks the table RAM one
// entry per cycle through its single read port: it ends early for a sector below
// the heap start, stops at the first entry that holds the cluster, and on a miss
// reads every entry in use (twelve at most).
// A new request may be given in the cycle done is high.
// Configuration writes are taken at any time but belong while busy is low.
`default_nettype none

module cluster_extent_allocator_mapper_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] req_bytes,
    input  wire logic [3:0]  entry_select,
    input  wire logic [31:0] sector_address,
    input  wire logic [8:0]  byte_offset,
    input  wire logic [9:0]  read_length,
    output logic      [2:0]  status,
    output logic      [31:0] alloc_cluster,
    output logic      [3:0]  matched_entry,
    output logic      [31:0] file_pos,
    output logic      [9:0]  copy_length,
    output logic      [9:0]  fill_length
);

    ceam_pkg::ctrl_t   ctrl;
    ceam_pkg::stat_t   stat;
    ceam_pkg::result_t result;

    ceam_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    ceam_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .req_bytes      (req_bytes),
        .entry_select   (entry_select),
        .sector_address (sector_address),
        .byte_offset    (byte_offset),
        .read_length    (read_length),
        .ctrl           (ctrl),
        .stat           (stat),
        .result         (result)
    );

    assign status        = result.status;
    assign alloc_cluster = result.alloc_cluster;
    assign matched_entry = result.matched_entry;
    assign file_pos      = result.file_pos;
    assign copy_length   = result.copy_length;
    assign fill_length   = result.fill_length;

endmodule

`default_nettype wire
